@@ hw/rtl/llte_pkg.sv @@
// Shared constants, types and helpers of the linked list table engine.
`default_nettype none

package llte_pkg;

	localparam int NODES  = 64;
	localparam int IDX_W  = $clog2(NODES + 1);
	localparam int ADDR_W = $clog2(NODES);
	localparam int VAL_W  = 32;
	localparam int CNT_W  = 7;

	typedef logic [IDX_W-1:0] idx_t;

	localparam idx_t NULL_IDX = idx_t'(NODES);

	typedef enum logic [2:0] {
		REQ_INS_HEAD = 3'd0,
		REQ_INS_SORT = 3'd1,
		REQ_SEARCH   = 3'd2,
		REQ_REMOVE   = 3'd3,
		REQ_CLEAR    = 3'd4
	} req_t;

	typedef enum logic [1:0] {
		STAT_OK   = 2'd0,
		STAT_FULL = 2'd1,
		STAT_MISS = 2'd2
	} status_t;

	typedef enum logic [7:0] {
		ST_IDLE   = 8'b0000_0001,
		ST_ALLOC  = 8'b0000_0010,
		ST_PLACE  = 8'b0000_0100,
		ST_WALK   = 8'b0000_1000,
		ST_LINK_A = 8'b0001_0000,
		ST_LINK_B = 8'b0010_0000,
		ST_UNLINK = 8'b0100_0000,
		ST_FIN    = 8'b1000_0000
	} state_t;

	// A link at or beyond the pool size ends a chain.
	function automatic idx_t next_idx(idx_t link);
		return (link >= NULL_IDX) ? NULL_IDX : link;
	endfunction

endpackage

`default_nettype wire

@@ hw/rtl/llte_ram.sv @@
// Simple dual-port RAM with one write port and one registered read port.
`default_nettype none

module llte_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64,
	localparam int AW = $clog2(DEPTH)
) (
	input  wire logic             clk,
	input  wire logic             wr_en,
	input  wire logic [AW-1:0]    wr_addr,
	input  wire logic [WIDTH-1:0] wr_data,
	input  wire logic [AW-1:0]    rd_addr,
	output logic      [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		rd_data <= mem[rd_addr];
	end

endmodule

`default_nettype wire

@@ hw/rtl/linked_list_table_engine.sv @@
// Top level of the linked list table engine: request sequencer over the node pool.
//
// Requests arrive on the input channel (in_valid, in_stall, req_type, value) and
// each one produces exactly one transaction on the output channel (out_valid,
// out_stall, found, status, list_empty, entry_count). One request is worked on
// at a time; in_stall is high while a request is in progress.
// Insert at head passes through ST_PLACE, ST_LINK_A and ST_FIN, with ST_ALLOC
// first when it reuses a freed node. Clear, unknown requests, refused inserts and
// lookups in an empty list go straight to ST_FIN. Sorted insert, search and remove
// walk the list one node per cycle through the registered read port of the node
// memories. The result sits in an output register, so the next request may be
// accepted while the previous result is still stalled; a finished request waits
// in its final state while that register is still occupied, and a remove that
// found its node also waits there while the freed node is pushed.
// Reset clears the list head, the free chain, the pool and the entry count and
// empties the output register. The node memories are not cleared and need no
// clearing pass; only written nodes are ever followed.
`default_nettype none

module linked_list_table_engine
	import llte_pkg::*;
(
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    in_valid,
	output logic                         in_stall,
	input  wire logic [2:0]              req_type,
	input  wire logic signed [VAL_W-1:0] value,
	output logic                         out_valid,
	input  wire logic                    out_stall,
	output logic                         found,
	output logic [1:0]                   status,
	output logic                         list_empty,
	output logic [CNT_W-1:0]             entry_count
);

	state_t              state_q;
	req_t                req_q;
	logic signed [VAL_W-1:0] val_q;
	idx_t                head_q, free_q, fresh_q, held_q;
	idx_t                cur_q, prev_q, n_q, nxt_q, steps_q;
	logic                res_found_q;
	status_t             res_status_q;

	logic                out_valid_q, found_q, list_empty_q;
	logic [1:0]          status_q;
	logic [CNT_W-1:0]    entry_count_q;

	logic [ADDR_W-1:0]   rd_addr;
	logic [VAL_W-1:0]    rd_val_raw;
	logic signed [VAL_W-1:0] rd_val;
	idx_t                rd_link;
	logic                val_we;
	logic                link_we;
	logic [ADDR_W-1:0]   link_waddr;
	idx_t                link_wdata;
	idx_t                nxt;
	idx_t                steps_inc;
	logic                walk_go;
	logic                out_free;
	logic                is_insert_in;
	logic                fin_fire;

	llte_ram #(.WIDTH(VAL_W), .DEPTH(NODES)) u_val_ram (
		.clk     (clk),
		.wr_en   (val_we),
		.wr_addr (n_q[ADDR_W-1:0]),
		.wr_data (val_q),
		.rd_addr (rd_addr),
		.rd_data (rd_val_raw)
	);

	llte_ram #(.WIDTH(IDX_W), .DEPTH(NODES)) u_link_ram (
		.clk     (clk),
		.wr_en   (link_we),
		.wr_addr (link_waddr),
		.wr_data (link_wdata),
		.rd_addr (rd_addr),
		.rd_data (rd_link)
	);

	assign rd_val       = rd_val_raw;
	assign nxt          = next_idx(rd_link);
	assign steps_inc    = idx_t'(steps_q + 1'b1);
	assign out_free     = !out_valid_q || !out_stall;
	assign is_insert_in = (req_type == REQ_INS_HEAD) || (req_type == REQ_INS_SORT);
	assign fin_fire     = (state_q == ST_FIN) && out_free &&
	                      !((req_q == REQ_REMOVE) && res_found_q);

	always_comb begin
		walk_go    = (req_q == REQ_INS_SORT) ? (rd_val < val_q) : (rd_val != val_q);
		rd_addr    = cur_q[ADDR_W-1:0];
		val_we     = 1'b0;
		link_we    = 1'b0;
		link_waddr = cur_q[ADDR_W-1:0];
		link_wdata = free_q;
		case (state_q)
			ST_IDLE: begin
				rd_addr = is_insert_in ? free_q[ADDR_W-1:0] : head_q[ADDR_W-1:0];
			end
			ST_PLACE: begin
				rd_addr = head_q[ADDR_W-1:0];
				val_we  = 1'b1;
			end
			ST_WALK: begin
				rd_addr = nxt[ADDR_W-1:0];
			end
			ST_LINK_A: begin
				link_we    = 1'b1;
				link_waddr = n_q[ADDR_W-1:0];
				link_wdata = cur_q;
			end
			ST_LINK_B: begin
				link_we    = 1'b1;
				link_waddr = prev_q[ADDR_W-1:0];
				link_wdata = n_q;
			end
			ST_UNLINK: begin
				link_we    = prev_q < NULL_IDX;
				link_waddr = prev_q[ADDR_W-1:0];
				link_wdata = nxt_q;
			end
			ST_FIN: begin
				// In the remove path the freed node is pushed here.
				link_we    = (req_q == REQ_REMOVE) && res_found_q;
				link_waddr = cur_q[ADDR_W-1:0];
				link_wdata = free_q;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			req_q         <= REQ_INS_HEAD;
			val_q         <= '0;
			head_q        <= NULL_IDX;
			free_q        <= NULL_IDX;
			fresh_q       <= '0;
			held_q        <= '0;
			cur_q         <= NULL_IDX;
			prev_q        <= NULL_IDX;
			n_q           <= '0;
			nxt_q         <= NULL_IDX;
			steps_q       <= '0;
			res_found_q   <= 1'b0;
			res_status_q  <= STAT_OK;
			out_valid_q   <= 1'b0;
			found_q       <= 1'b0;
			status_q      <= STAT_OK;
			list_empty_q  <= 1'b1;
			entry_count_q <= '0;
		end else begin
			if (fin_fire) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						req_q        <= req_t'(req_type);
						val_q        <= value;
						res_found_q  <= 1'b0;
						res_status_q <= STAT_OK;
						prev_q       <= NULL_IDX;
						cur_q        <= head_q;
						steps_q      <= '0;
						case (req_type)
							REQ_INS_HEAD, REQ_INS_SORT: begin
								if (free_q < NULL_IDX) begin
									state_q <= ST_ALLOC;
								end else if (fresh_q < NULL_IDX) begin
									n_q     <= fresh_q;
									fresh_q <= idx_t'(fresh_q + 1'b1);
									state_q <= ST_PLACE;
								end else begin
									res_status_q <= STAT_FULL;
									state_q      <= ST_FIN;
								end
							end
							REQ_SEARCH, REQ_REMOVE: begin
								if (head_q < NULL_IDX && held_q != '0) begin
									state_q <= ST_WALK;
								end else begin
									res_status_q <= STAT_MISS;
									state_q      <= ST_FIN;
								end
							end
							REQ_CLEAR: begin
								head_q  <= NULL_IDX;
								free_q  <= NULL_IDX;
								fresh_q <= '0;
								held_q  <= '0;
								state_q <= ST_FIN;
							end
							default: begin
								state_q <= ST_FIN;
							end
						endcase
					end
				end
				ST_ALLOC: begin
					n_q     <= free_q;
					free_q  <= nxt;
					state_q <= ST_PLACE;
				end
				ST_PLACE: begin
					cur_q   <= head_q;
					prev_q  <= NULL_IDX;
					steps_q <= '0;
					if (req_q == REQ_INS_SORT && head_q < NULL_IDX && held_q != '0) begin
						state_q <= ST_WALK;
					end else begin
						state_q <= ST_LINK_A;
					end
				end
				ST_WALK: begin
					if (walk_go) begin
						prev_q  <= cur_q;
						cur_q   <= nxt;
						steps_q <= steps_inc;
						if (!(nxt < NULL_IDX && steps_inc < held_q)) begin
							if (req_q == REQ_INS_SORT) begin
								state_q <= ST_LINK_A;
							end else begin
								res_status_q <= STAT_MISS;
								state_q      <= ST_FIN;
							end
						end
					end else if (req_q == REQ_INS_SORT) begin
						state_q <= ST_LINK_A;
					end else begin
						res_found_q <= 1'b1;
						nxt_q       <= nxt;
						state_q     <= (req_q == REQ_REMOVE) ? ST_UNLINK : ST_FIN;
					end
				end
				ST_LINK_A: begin
					if (prev_q < NULL_IDX) begin
						state_q <= ST_LINK_B;
					end else begin
						head_q  <= n_q;
						held_q  <= idx_t'(held_q + 1'b1);
						state_q <= ST_FIN;
					end
				end
				ST_LINK_B: begin
					held_q  <= idx_t'(held_q + 1'b1);
					state_q <= ST_FIN;
				end
				ST_UNLINK: begin
					if (!(prev_q < NULL_IDX)) begin
						head_q <= nxt_q;
					end
					if (held_q != '0) begin
						held_q <= idx_t'(held_q - 1'b1);
					end
					state_q <= ST_FIN;
				end
				ST_FIN: begin
					if ((req_q == REQ_REMOVE) && res_found_q) begin
						free_q      <= cur_q;
						res_found_q <= 1'b0;
					end
					if (fin_fire) begin
						found_q       <= (req_q == REQ_SEARCH) || (req_q == REQ_REMOVE) ?
						                 (res_status_q == STAT_OK) : 1'b0;
						status_q      <= res_status_q;
						list_empty_q  <= (held_q == '0) || !(head_q < NULL_IDX);
						entry_count_q <= CNT_W'(held_q);
						state_q       <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign in_stall    = (state_q != ST_IDLE);
	assign out_valid   = out_valid_q;
	assign found       = found_q;
	assign status      = status_q;
	assign list_empty  = list_empty_q;
	assign entry_count = entry_count_q;

	a_out_from_fin: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(state_q == ST_FIN))
		else $error("Result appeared without a finished request.");

	a_empty_count: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && entry_count == '0) |-> list_empty)
		else $error("Zero entries reported without the empty flag.");

	a_head_vs_count: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE) |-> ((head_q < NULL_IDX) == (held_q != '0)))
		else $error("List head and entry count disagree.");

	a_held_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE) |-> (held_q <= fresh_q))
		else $error("More entries held than pool nodes handed out.");

endmodule

`default_nettype wire

@@ verif/linked_list_table_engine_tb.sv @@
// Self-checking testbench for the linked list table engine with a shadow list predictor.
module linked_list_table_engine_tb;
	import llte_pkg::*;

	localparam int          TIMEOUT_CYCLES = 600_000;
	localparam int          HOLD_CYCLES    = 400;
	localparam logic [2:0]  REQ_UNUSED_LO  = 3'd5;
	localparam logic [2:0]  REQ_UNUSED_HI  = 3'd7;
	localparam logic signed [VAL_W-1:0] VAL_MIN = 32'sh8000_0000;
	localparam logic signed [VAL_W-1:0] VAL_MAX = 32'sh7fff_ffff;

	typedef struct {
		logic             found;
		logic [1:0]       status;
		logic             empty;
		logic [CNT_W-1:0] count;
	} list_reply_t;

	class list_shadow;
		int          node_val[NODES];
		idx_t        node_nxt[NODES];
		idx_t        head;
		idx_t        free_head;
		int          fresh;
		int          held;
		list_reply_t due_replies[$];
		int          errors;

		function new();
			errors = 0;
			wipe();
		endfunction

		function void wipe();
			head = NULL_IDX;
			free_head = NULL_IDX;
			fresh = 0;
			held = 0;
		endfunction

		function idx_t follow(idx_t n);
			if (n >= NULL_IDX || node_nxt[n] >= NULL_IDX)
				return NULL_IDX;
			return node_nxt[n];
		endfunction

		function idx_t grab_node();
			idx_t n;
			if (free_head < NULL_IDX) begin
				n = free_head;
				free_head = follow(n);
				return n;
			end
			if (fresh < NODES) begin
				n = idx_t'(fresh);
				fresh++;
				return n;
			end
			return NULL_IDX;
		endfunction

		function int pending();
			return due_replies.size();
		endfunction

		function void note_request(logic [2:0] code, logic signed [VAL_W-1:0] v);
			list_reply_t r;
			idx_t        n;
			idx_t        cur;
			idx_t        prev;
			int          steps;
			r.found = 1'b0;
			r.status = STAT_OK;
			cur = head;
			prev = NULL_IDX;
			steps = 0;
			case (code)
				REQ_INS_HEAD, REQ_INS_SORT: begin
					n = grab_node();
					if (n == NULL_IDX) begin
						r.status = STAT_FULL;
					end else begin
						node_val[n] = v;
						if (code == REQ_INS_SORT) begin
							while (cur < NULL_IDX && steps < held && node_val[cur] < v) begin
								prev = cur;
								cur = follow(cur);
								steps++;
							end
						end
						if (prev == NULL_IDX) begin
							node_nxt[n] = head;
							head = n;
						end else begin
							node_nxt[n] = follow(prev);
							node_nxt[prev] = n;
						end
						held++;
					end
				end
				REQ_SEARCH, REQ_REMOVE: begin
					while (cur < NULL_IDX && steps < held && node_val[cur] != v) begin
						prev = cur;
						cur = follow(cur);
						steps++;
					end
					if (cur >= NULL_IDX || steps >= held) begin
						r.status = STAT_MISS;
					end else begin
						r.found = 1'b1;
						if (code == REQ_REMOVE) begin
							if (prev == NULL_IDX)
								head = follow(cur);
							else
								node_nxt[prev] = follow(cur);
							node_nxt[cur] = free_head;
							free_head = cur;
							if (held > 0)
								held--;
						end
					end
				end
				REQ_CLEAR: begin
					wipe();
				end
				default: begin
				end
			endcase
			r.empty = (held == 0 || head >= NULL_IDX);
			r.count = CNT_W'(held);
			due_replies.push_back(r);
		endfunction

		function void compare(string field, int want, int got);
			if (want != got) begin
				$display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
				errors++;
			end
		endfunction

		function void check_reply(logic f, logic [1:0] s, logic e, logic [CNT_W-1:0] c);
			list_reply_t r;
			if (due_replies.size() == 0) begin
				$display("%0t: unexpected result, expected none, actual found %0d status %0d empty %0d count %0d",
					$time, f, s, e, c);
				errors++;
				return;
			end
			r = due_replies.pop_front();
			compare("found", r.found, f);
			compare("status", r.status, s);
			compare("list_empty", r.empty, e);
			compare("entry_count", r.count, c);
		endfunction
	endclass

	logic                    clk = 1'b0;
	logic                    arst_n = 1'b0;
	logic                    in_valid = 1'b0;
	logic                    in_stall;
	logic [2:0]              req_type = REQ_SEARCH;
	logic signed [VAL_W-1:0] value = '0;
	logic                    out_valid;
	logic                    out_stall = 1'b0;
	logic                    found;
	logic [1:0]              status;
	logic                    list_empty;
	logic [CNT_W-1:0]        entry_count;

	list_shadow tracker = new();
	int         send_idle_pct = 0;
	int         recv_idle_pct = 0;
	int         hold_left = 0;
	bit         hold_go = 1'b0;

	linked_list_table_engine i_dut (
		.clk,
		.arst_n,
		.in_valid,
		.in_stall,
		.req_type,
		.value,
		.out_valid,
		.out_stall,
		.found,
		.status,
		.list_empty,
		.entry_count
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			tracker.check_reply(found, status, list_empty, entry_count);
		if (hold_go) begin
			hold_left = HOLD_CYCLES;
			hold_go = 1'b0;
		end
		if (hold_left > 0) begin
			out_stall <= 1'b1;
			hold_left--;
		end else begin
			out_stall <= ($urandom_range(99) < recv_idle_pct);
		end
	end

	task automatic send_request(input logic [2:0] code, input logic signed [VAL_W-1:0] v);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		req_type <= code;
		value <= v;
		do @(posedge clk); while (in_stall);
		tracker.note_request(code, v);
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		do @(posedge clk); while (tracker.pending() > 0);
	endtask

	function automatic logic signed [VAL_W-1:0] pick_value();
		int roll;
		roll = $urandom_range(99);
		if (roll < 55)
			return int'($urandom_range(15)) - 8;
		if (roll < 88)
			return $urandom;
		case ($urandom_range(3))
			0: return VAL_MIN;
			1: return VAL_MAX;
			2: return '0;
			default: return -1;
		endcase
	endfunction

	function automatic logic [2:0] pick_code(int mode);
		int roll;
		roll = $urandom_range(99);
		if (roll < 1)
			return REQ_CLEAR;
		if (roll < 3)
			return 3'($urandom_range(REQ_UNUSED_HI, REQ_UNUSED_LO));
		case (mode)
			0: begin
				if (roll < 45) return REQ_INS_SORT;
				if (roll < 72) return REQ_INS_HEAD;
				if (roll < 86) return REQ_SEARCH;
				return REQ_REMOVE;
			end
			1: begin
				if (roll < 15) return REQ_INS_SORT;
				if (roll < 22) return REQ_INS_HEAD;
				if (roll < 45) return REQ_SEARCH;
				return REQ_REMOVE;
			end
			default: begin
				if (roll < 30) return REQ_INS_SORT;
				if (roll < 45) return REQ_INS_HEAD;
				if (roll < 72) return REQ_SEARCH;
				return REQ_REMOVE;
			end
		endcase
	endfunction

	// Episodes lean toward filling, draining or mixing so the pool reaches both full and empty.
	task automatic run_random(input int items, input int hold_at);
		int         done;
		int         mode;
		int         left;
		logic [2:0] code;
		done = 0;
		mode = 0;
		left = 0;
		while (done < items) begin
			if (left == 0) begin
				mode = $urandom_range(2);
				left = $urandom_range(120, 20);
			end
			left--;
			code = pick_code(mode);
			send_request(code, pick_value());
			if (code <= REQ_CLEAR) begin
				done++;
				if (done == hold_at)
					hold_go = 1'b1;
			end
		end
	endtask

	initial begin
		logic signed [VAL_W-1:0] kept;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		send_idle_pct = 17;
		recv_idle_pct = 54;

		send_request(REQ_SEARCH, 32'sd0);
		send_request(REQ_REMOVE, VAL_MIN);
		send_request(REQ_INS_HEAD, VAL_MAX);
		send_request(REQ_INS_SORT, VAL_MIN);
		send_request(REQ_INS_SORT, 32'sd0);
		send_request(REQ_INS_SORT, 32'sd0);
		send_request(REQ_INS_SORT, VAL_MAX);
		send_request(REQ_INS_HEAD, -32'sd1);
		send_request(REQ_INS_SORT, 32'sd5);
		send_request(REQ_SEARCH, VAL_MIN);
		send_request(REQ_SEARCH, 32'sd12345);
		send_request(REQ_REMOVE, VAL_MAX);
		send_request(REQ_REMOVE, -32'sd1);
		send_request(REQ_REMOVE, 32'sd0);
		send_request(REQ_INS_HEAD, 32'sd7);
		send_request(REQ_INS_SORT, 32'sd7);
		send_request(REQ_UNUSED_LO, VAL_MAX);
		send_request(REQ_UNUSED_LO + 3'd1, VAL_MIN);
		send_request(REQ_UNUSED_HI, 32'sd7);
		send_request(REQ_CLEAR, 32'sd7);
		send_request(REQ_SEARCH, 32'sd7);
		send_request(REQ_INS_SORT, 32'sd3);
		send_request(REQ_REMOVE, 32'sd3);
		send_request(REQ_REMOVE, 32'sd3);

		// Fill the pool past capacity, free one node, reuse it and get refused again.
		send_request(REQ_CLEAR, $urandom);
		kept = pick_value();
		send_request(REQ_INS_SORT, kept);
		repeat (NODES + 1)
			send_request($urandom_range(1) ? REQ_INS_SORT : REQ_INS_HEAD, pick_value());
		send_request(REQ_REMOVE, kept);
		send_request(REQ_INS_SORT, pick_value());
		send_request(REQ_INS_HEAD, pick_value());

		run_random(355, 150);
		wait_drained();
		send_idle_pct = 54;
		recv_idle_pct = 17;
		run_random(355, -1);
		wait_drained();
		send_idle_pct = 0;
		recv_idle_pct = 0;
		run_random(355, -1);

		wait_drained();
		repeat (NODES + 10) @(posedge clk);
		if (tracker.errors == 0 && tracker.pending() == 0)
			$display("linked_list_table_engine_tb: clean");
		else
			$display("linked_list_table_engine_tb: errors");
		$finish;
	end

	initial begin
		#(4 * TIMEOUT_CYCLES);
		$display("%0t: timeout with %0d results outstanding", $time, tracker.pending());
		$display("linked_list_table_engine_tb: errors");
		$finish;
	end

endmodule

@@ sim.f @@
hw/rtl/llte_pkg.sv
hw/rtl/llte_ram.sv
hw/rtl/linked_list_table_engine.sv
verif/linked_list_table_engine_tb.sv
